[design/pbfh_pkg.sv]
// Package for the byte pipe: buffer sizing, item types, operation and status codes.
// No dependencies; imported by pbfh_out_fifo and the top module.
`timescale 1ns / 1ps

package pbfh_pkg;

  // Buffer sizing
  localparam int BUFFER_BYTES = 4096;
  localparam int MAX_READ     = 64;
  localparam int PTR_W        = $clog2(BUFFER_BYTES);
  localparam int CNT_W        = $clog2(BUFFER_BYTES + 1);
  localparam int SUM_W        = CNT_W + 1;

  // Fixed field widths
  localparam int FUNC_W = 3;
  localparam int BYTE_W = 8;
  localparam int REQ_W  = 7;
  localparam int STAT_W = 2;
  localparam int FILL_W = 13;
  localparam int CMP_W  = (CNT_W > REQ_W) ? CNT_W : REQ_W;

  // Operation codes
  localparam logic [FUNC_W-1:0] FUNC_WRITE    = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_READ     = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLOSE_RD = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_CLOSE_WR = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_POLL     = 3'd4;

  // Status codes
  localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
  localparam logic [STAT_W-1:0] STAT_WBLOCK = 2'd1;
  localparam logic [STAT_W-1:0] STAT_BROKEN = 2'd2;
  localparam logic [STAT_W-1:0] STAT_EOF    = 2'd3;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [BYTE_W-1:0] data_in;
    logic [REQ_W-1:0]  read_count;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data_out;
    logic              data_valid;
    logic              last;
    logic [STAT_W-1:0] status;
    logic              poll_readable;
    logic              poll_writable;
    logic              poll_hangup;
    logic [FILL_W-1:0] fill_level;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_READ = 2'b10
  } state_e;

endpackage

[design/pbfh_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module pbfh_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/pbfh_out_fifo.sv]
// Two-entry result FIFO that decouples the pipe core from the output stall.
// Depends on pbfh_pkg for the result item type.
`timescale 1ns / 1ps

module pbfh_out_fifo
  import pbfh_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  out_item_t push_item_i,
  output logic [1:0] count_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  out_item_t  slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       pop;

  assign out_valid_o = (count_q != 2'd0);
  assign out_item_o  = slot_q[rd_ptr_q];
  assign count_o     = count_q;
  assign pop         = out_valid_o & ~out_stall_i;

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push_i} - {1'b0, pop};
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

[design/pipe_byte_fifo_with_hangup_top.sv]
// Byte pipe: circular byte FIFO in a synchronous RAM with latched hangup flags.
// A non-read result passes the result stage and the output FIFO; a read's first byte also passes
// the read state and the RAM read register, then one byte per cycle while result slots are free.
// One non-read item per cycle unless the output stalls; a read stalls the input to its last byte.
// Reset clears pointers, count and flags at once; RAM contents stay undefined, no clear pass.
// Depends on pbfh_pkg, pbfh_ram and pbfh_out_fifo.
`timescale 1ns / 1ps

module pipe_byte_fifo_with_hangup_top
  import pbfh_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  state_e            state_q, state_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              reader_gone_q, reader_gone_d;
  logic              writer_gone_q, writer_gone_d;
  logic [REQ_W-1:0]  remain_q, remain_d;

  // result stage between the core and the output FIFO
  logic              pend_valid_q, pend_valid_d;
  logic              pend_byte_q, pend_byte_d;
  out_item_t         pend_res_q, pend_res_d;

  logic              ram_we, ram_re;
  logic [PTR_W-1:0]  ram_waddr;
  logic [BYTE_W-1:0] ram_rdata;

  logic [1:0]        fifo_count;
  logic              pop, slot_ok, in_accept;
  out_item_t         push_item;

  logic [SUM_W-1:0]  tail_sum;
  logic [PTR_W-1:0]  tail;
  logic [PTR_W-1:0]  rd_ptr_inc;
  logic [REQ_W-1:0]  want_sat;
  logic [REQ_W-1:0]  take;
  logic              full;

  assign pop     = out_valid_o & ~out_stall_i;
  assign slot_ok = ({1'b0, fifo_count} + {2'b00, pend_valid_q}) < (3'd2 + {2'b00, pop});

  assign in_stall_o = ~((state_q == ST_IDLE) & slot_ok);
  assign in_accept  = in_valid_i & ~in_stall_o;

  assign full = (count_q == CNT_W'(BUFFER_BYTES));

  always_comb begin
    tail_sum = SUM_W'(rd_ptr_q) + SUM_W'(count_q);
    if (tail_sum >= SUM_W'(BUFFER_BYTES)) begin
      tail_sum = tail_sum - SUM_W'(BUFFER_BYTES);
    end
    tail = tail_sum[PTR_W-1:0];
  end

  assign rd_ptr_inc = (rd_ptr_q == PTR_W'(BUFFER_BYTES - 1)) ? '0 : rd_ptr_q + 1'b1;

  always_comb begin
    want_sat = (in_item_i.read_count > REQ_W'(MAX_READ)) ? REQ_W'(MAX_READ)
                                                         : in_item_i.read_count;
    if (CMP_W'(count_q) < CMP_W'(want_sat)) begin
      take = REQ_W'(count_q);
    end else begin
      take = want_sat;
    end
  end

  always_comb begin
    state_d       = state_q;
    rd_ptr_d      = rd_ptr_q;
    count_d       = count_q;
    reader_gone_d = reader_gone_q;
    writer_gone_d = writer_gone_q;
    remain_d      = remain_q;
    pend_valid_d  = 1'b0;
    pend_byte_d   = 1'b0;
    pend_res_d    = '0;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_waddr     = tail;

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          pend_valid_d    = 1'b1;
          pend_res_d.last = 1'b1;
          case (in_item_i.func)
            FUNC_WRITE: begin
              if (reader_gone_q) begin
                pend_res_d.status = STAT_BROKEN;
              end else if (full) begin
                pend_res_d.status = STAT_WBLOCK;
              end else begin
                ram_we  = 1'b1;
                count_d = count_q + 1'b1;
              end
            end
            FUNC_READ: begin
              if (in_item_i.read_count == '0) begin
                pend_res_d.status = STAT_OK;
              end else if (count_q == '0) begin
                pend_res_d.status = writer_gone_q ? STAT_EOF : STAT_WBLOCK;
              end else begin
                // hand off to the byte run; no result this cycle
                pend_valid_d = 1'b0;
                remain_d     = take;
                state_d      = ST_READ;
              end
            end
            FUNC_CLOSE_RD: reader_gone_d = 1'b1;
            FUNC_CLOSE_WR: writer_gone_d = 1'b1;
            FUNC_POLL: begin
              pend_res_d.poll_readable = (count_q != '0) | writer_gone_q;
              pend_res_d.poll_writable = ~full & ~reader_gone_q;
              pend_res_d.poll_hangup   = reader_gone_q | writer_gone_q;
              pend_res_d.fill_level    = FILL_W'(count_q);
            end
            default: ;
          endcase
        end
      end
      ST_READ: begin
        // issue one RAM read per free result slot
        if (slot_ok) begin
          ram_re                = 1'b1;
          rd_ptr_d              = rd_ptr_inc;
          count_d               = count_q - 1'b1;
          remain_d              = remain_q - 1'b1;
          pend_valid_d          = 1'b1;
          pend_byte_d           = 1'b1;
          pend_res_d.data_valid = 1'b1;
          pend_res_d.last       = (remain_q == REQ_W'(1));
          if (remain_q == REQ_W'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      rd_ptr_q      <= '0;
      count_q       <= '0;
      reader_gone_q <= 1'b0;
      writer_gone_q <= 1'b0;
      remain_q      <= '0;
      pend_valid_q  <= 1'b0;
      pend_byte_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      rd_ptr_q      <= rd_ptr_d;
      count_q       <= count_d;
      reader_gone_q <= reader_gone_d;
      writer_gone_q <= writer_gone_d;
      remain_q      <= remain_d;
      pend_valid_q  <= pend_valid_d;
      pend_byte_q   <= pend_byte_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_res_q <= pend_res_d;
  end

  always_comb begin
    push_item = pend_res_q;
    if (pend_byte_q) begin
      push_item.data_out = ram_rdata;
    end
  end

  pbfh_ram #(
    .DEPTH (BUFFER_BYTES),
    .WIDTH (BYTE_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (in_item_i.data_in),
    .re_i    (ram_re),
    .raddr_i (rd_ptr_q),
    .rdata_o (ram_rdata)
  );

  pbfh_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (pend_valid_q),
    .push_item_i (push_item),
    .count_o     (fifo_count),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  // Occupancy never passes the buffer size
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(BUFFER_BYTES))
    else $error("byte count above buffer size");

  // Result FIFO never overflows
  a_fifo_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q |-> (fifo_count != 2'd2) || pop)
    else $error("result FIFO overflow");

  // A byte run always has bytes left to send
  a_run_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |-> (remain_q != '0) && (count_q != '0))
    else $error("read run with nothing left");

  // An accepted write with room and a live reader grows the queue by one
  a_write_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && (in_item_i.func == FUNC_WRITE) && !reader_gone_q && !full)
      |=> (count_q == $past(count_q) + 1'b1))
    else $error("write did not store a byte");

endmodule
